>>> design/cma_pkg.sv
// ----------------------------------------------------------------------------
// cma_pkg
// Shared types and constants of the centered moving average core: register
// map of the configuration port and the control bundle of a divide job.
// ----------------------------------------------------------------------------
`default_nettype none

package cma_pkg;

  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;
  localparam int WIN_LEN_W = 7;

  localparam logic [WIN_LEN_W-1:0] WIN_LEN_RESET = 7'd3;

  // word index of each register (paddr[CFG_AW-1:2])
  localparam logic [CFG_AW-3:0] REG_WINDOW_LEN = 1'b0;

  typedef struct packed {
    logic pass;
    logic last;
  } cma_job_ctl_t;

endpackage

`default_nettype wire

>>> design/centered_moving_average_core.sv
// ----------------------------------------------------------------------------
// centered_moving_average_core
// Centered moving average of length m (register window_len) over series of
// signed samples. Each in_ beat writes one sample into a circular buffer
// memory with one read port; the window sum is updated by read-modify-write
// (one read of the sample leaving the window, one of the even-length end
// sample), and the quotient comes from an iterative radix-4 divider, which
// overlaps the next sample; the window sequencer stalls input until it has
// handed its divide job on. The first sample of a series and the first after
// a length change replace the drop step (full window only) with a sum rebuild
// over min(span, samples held) stored samples.
// For m of 0 or 1 a sample passes through unchanged. Results leave through
// an output register; a stalled out_ beat holds the next result in the
// divider and the one after in the window sequencer, then stalls input.
// ----------------------------------------------------------------------------
`default_nettype none

module centered_moving_average_core import cma_pkg::*; #(
  parameter int MAX_WINDOW   = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [CFG_AW-1:0]              paddr,
  input  logic [CFG_DW-1:0]              pwdata,
  output logic [CFG_DW-1:0]              prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           in_series_end,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_average,
  output logic                           out_result_last
);

  localparam int NUM_W = SAMPLE_WIDTH + $clog2(MAX_WINDOW + 1) + 1;
  localparam int DEN_W = $clog2(2*MAX_WINDOW + 1);

  logic [WIN_LEN_W-1:0]           window_len;
  logic                           job_valid, job_ready;
  cma_job_ctl_t                   job_ctl;
  logic signed [NUM_W-1:0]        job_num;
  logic [DEN_W-1:0]               job_den;
  logic                           res_valid, res_ready, res_last;
  logic signed [SAMPLE_WIDTH-1:0] res_average;

  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_average_r;
  logic                           out_last_r;

  cma_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .window_len (window_len)
  );

  cma_window #(
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_window (
    .clk           (clk),
    .rst_n         (rst_n),
    .window_len    (window_len),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_sample),
    .in_series_end (in_series_end),
    .job_valid     (job_valid),
    .job_ready     (job_ready),
    .job_ctl       (job_ctl),
    .job_num       (job_num),
    .job_den       (job_den)
  );

  cma_div #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .NUM_W        (NUM_W),
    .DEN_W        (DEN_W)
  ) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_valid   (job_valid),
    .job_ready   (job_ready),
    .job_ctl     (job_ctl),
    .job_num     (job_num),
    .job_den     (job_den),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_average (res_average),
    .res_last    (res_last)
  );

  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_average_r <= res_average;
      out_last_r    <= res_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_average     = out_average_r;
  assign out_result_last = out_last_r;

endmodule

`default_nettype wire

>>> design/cma_regs.sv
// ----------------------------------------------------------------------------
// cma_regs
// APB-style configuration register file: holds the window length.
// ----------------------------------------------------------------------------
`default_nettype none

module cma_regs import cma_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [CFG_AW-1:0]    paddr,
  input  logic [CFG_DW-1:0]    pwdata,
  output logic [CFG_DW-1:0]    prdata,
  output logic                 pready,
  output logic [WIN_LEN_W-1:0] window_len
);

  logic [WIN_LEN_W-1:0] window_len_r;
  logic [CFG_AW-3:0]    reg_idx;
  logic                 wr_en;

  assign reg_idx    = paddr[CFG_AW-1:2];
  assign wr_en      = psel && penable && pwrite && (reg_idx == REG_WINDOW_LEN);
  assign pready     = 1'b1;
  assign window_len = window_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= WIN_LEN_RESET;
    end else if (wr_en) begin
      window_len_r <= pwdata[WIN_LEN_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WINDOW_LEN: prdata = {{(CFG_DW-WIN_LEN_W){1'b0}}, window_len_r};
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> design/cma_window.sv
// ----------------------------------------------------------------------------
// cma_window
// Sample memory and window sequencer: stores each sample in a circular
// buffer, keeps the running window sum by read-modify-write, rebuilds it
// on a new series or a length change, and issues one divide job per result.
// ----------------------------------------------------------------------------
`default_nettype none

module cma_window import cma_pkg::*; #(
  parameter int MAX_WINDOW   = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [WIN_LEN_W-1:0]                   window_len,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]         in_sample,
  input  logic                                   in_series_end,
  output logic                                   job_valid,
  input  logic                                   job_ready,
  output cma_job_ctl_t                           job_ctl,
  output logic signed [SAMPLE_WIDTH+$clog2(MAX_WINDOW+1):0] job_num,
  output logic [$clog2(2*MAX_WINDOW+1)-1:0]      job_den
);

  localparam int LINE_DEPTH = MAX_WINDOW + 1;
  localparam int MEM_DEPTH  = MAX_WINDOW + 2;
  localparam int IDX_W      = $clog2(MEM_DEPTH);
  localparam int SUM_W      = SAMPLE_WIDTH + $clog2(LINE_DEPTH);
  localparam int NUM_W      = SUM_W + 1;
  localparam int DEN_W      = $clog2(2*MAX_WINDOW+1);

  typedef enum logic [4:0] {
    W_IDLE = 5'b00001,
    W_SUM  = 5'b00010,
    W_DROP = 5'b00100,
    W_FIN  = 5'b01000,
    W_JOB  = 5'b10000
  } win_state_t;

  win_state_t st_r, st_nxt;

  logic [IDX_W-1:0]               wp_r, wp_nxt, fill_r, fill_nxt;
  logic signed [SUM_W-1:0]        sum_r, sum_nxt;
  logic [IDX_W-1:0]               sum_span_r, sum_span_nxt;
  logic                           sum_ok_r, sum_ok_nxt;
  logic signed [SAMPLE_WIDTH-1:0] smp_r, smp_nxt;
  logic                           last_r, last_nxt;
  logic [IDX_W-1:0]               m_r, m_nxt, span_r, span_nxt, cnt_r, cnt_nxt;
  logic                           even_r, even_nxt;
  logic [IDX_W-1:0]               rd_idx_r, rd_idx_nxt;
  logic                           rd_vld_r, rd_vld_nxt;
  logic                           phase_r, phase_nxt;
  logic                           job_pass_r, job_pass_nxt;
  logic signed [NUM_W-1:0]        job_num_r, job_num_nxt;
  logic [DEN_W-1:0]               job_den_r, job_den_nxt;

  logic signed [SAMPLE_WIDTH-1:0] mem [MEM_DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] rd_data_r;
  logic                           mem_we;

  logic [31:0]             len_ext;
  logic [IDX_W-1:0]        m_eff, span_eff, fill_new, cnt_eff, wp_inc, rd_addr;
  logic                    even_eff, pass_eff, rebuild, rd_issue, full;
  logic [IDX_W:0]          addr_diff;
  logic signed [NUM_W-1:0] num2, ends;

  assign len_ext  = 32'(window_len);
  assign m_eff    = (len_ext > 32'(MAX_WINDOW)) ? IDX_W'(MAX_WINDOW) : IDX_W'(window_len);
  assign even_eff = ~m_eff[0];
  assign span_eff = m_eff + IDX_W'(even_eff);
  assign pass_eff = (m_eff <= IDX_W'(1));
  assign fill_new = (fill_r == IDX_W'(LINE_DEPTH)) ? fill_r : fill_r + IDX_W'(1);
  assign cnt_eff  = (span_eff < fill_new) ? span_eff : fill_new;
  assign rebuild  = !sum_ok_r || (sum_span_r != span_eff);
  assign wp_inc   = (wp_r == IDX_W'(MEM_DEPTH-1)) ? '0 : wp_r + IDX_W'(1);

  assign addr_diff = {1'b0, wp_r} - {1'b0, rd_idx_r};
  assign rd_addr   = addr_diff[IDX_W] ? IDX_W'(addr_diff + (IDX_W+1)'(MEM_DEPTH))
                                      : addr_diff[IDX_W-1:0];
  assign rd_issue  = (st_r == W_SUM) && (rd_idx_r < cnt_r);

  assign full = (fill_r >= span_r);
  assign num2 = {sum_r, 1'b0};
  assign ends = NUM_W'(smp_r) + NUM_W'(rd_data_r);

  assign in_stall  = (st_r != W_IDLE);
  assign job_valid = (st_r == W_JOB);
  assign job_ctl   = '{pass: job_pass_r, last: last_r};
  assign job_num   = job_num_r;
  assign job_den   = job_den_r;

  always_comb begin
    st_nxt       = st_r;
    wp_nxt       = wp_r;
    fill_nxt     = fill_r;
    sum_nxt      = sum_r;
    sum_span_nxt = sum_span_r;
    sum_ok_nxt   = sum_ok_r;
    smp_nxt      = smp_r;
    last_nxt     = last_r;
    m_nxt        = m_r;
    span_nxt     = span_r;
    even_nxt     = even_r;
    cnt_nxt      = cnt_r;
    rd_idx_nxt   = rd_idx_r;
    rd_vld_nxt   = rd_issue;
    phase_nxt    = phase_r;
    job_pass_nxt = job_pass_r;
    job_num_nxt  = job_num_r;
    job_den_nxt  = job_den_r;
    mem_we       = 1'b0;
    unique case (st_r)
      W_IDLE: begin
        if (in_valid) begin
          mem_we    = 1'b1;
          wp_nxt    = wp_inc;
          fill_nxt  = fill_new;
          smp_nxt   = in_sample;
          last_nxt  = in_series_end;
          m_nxt     = m_eff;
          span_nxt  = span_eff;
          even_nxt  = even_eff;
          cnt_nxt   = cnt_eff;
          phase_nxt = 1'b0;
          if (pass_eff) begin
            job_pass_nxt = 1'b1;
            job_num_nxt  = NUM_W'(in_sample);
            sum_ok_nxt   = 1'b0;
            st_nxt       = W_JOB;
          end else if (rebuild) begin
            sum_nxt    = '0;
            rd_idx_nxt = '0;
            st_nxt     = W_SUM;
          end else begin
            sum_nxt = sum_r + SUM_W'(in_sample);
            if (fill_r >= span_eff) begin
              rd_idx_nxt = span_eff;
              st_nxt     = W_DROP;
            end else begin
              rd_idx_nxt = span_eff - IDX_W'(1);
              st_nxt     = W_FIN;
            end
          end
        end
      end
      W_SUM: begin
        if (rd_issue) begin
          rd_idx_nxt = rd_idx_r + IDX_W'(1);
        end
        if (rd_vld_r) begin
          sum_nxt = sum_r + SUM_W'(rd_data_r);
        end
        if (!rd_issue && !rd_vld_r) begin
          sum_span_nxt = span_r;
          sum_ok_nxt   = 1'b1;
          rd_idx_nxt   = span_r - IDX_W'(1);
          st_nxt       = W_FIN;
        end
      end
      W_DROP: begin
        if (!phase_r) begin
          phase_nxt = 1'b1;
        end else begin
          sum_nxt    = sum_r - SUM_W'(rd_data_r);
          rd_idx_nxt = span_r - IDX_W'(1);
          phase_nxt  = 1'b0;
          st_nxt     = W_FIN;
        end
      end
      W_FIN: begin
        if (!phase_r) begin
          phase_nxt = 1'b1;
        end else begin
          phase_nxt    = 1'b0;
          job_pass_nxt = 1'b0;
          if (full) begin
            job_num_nxt = even_r ? num2 - ends : num2;
            job_den_nxt = DEN_W'({m_r, 1'b0});
            st_nxt      = W_JOB;
          end else if (last_r) begin
            job_num_nxt = NUM_W'(sum_r);
            job_den_nxt = DEN_W'(fill_r);
            st_nxt      = W_JOB;
          end else begin
            st_nxt = W_IDLE;
          end
        end
      end
      W_JOB: begin
        if (job_ready) begin
          if (last_r) begin
            fill_nxt   = '0;
            sum_nxt    = '0;
            sum_ok_nxt = 1'b0;
          end
          st_nxt = W_IDLE;
        end
      end
      default: st_nxt = W_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp_inc] <= in_sample;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= W_IDLE;
      wp_r     <= '0;
      fill_r   <= '0;
      sum_ok_r <= 1'b0;
      rd_vld_r <= 1'b0;
      phase_r  <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      wp_r     <= wp_nxt;
      fill_r   <= fill_nxt;
      sum_ok_r <= sum_ok_nxt;
      rd_vld_r <= rd_vld_nxt;
      phase_r  <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r      <= sum_nxt;
    sum_span_r <= sum_span_nxt;
    smp_r      <= smp_nxt;
    last_r     <= last_nxt;
    m_r        <= m_nxt;
    span_r     <= span_nxt;
    even_r     <= even_nxt;
    cnt_r      <= cnt_nxt;
    rd_idx_r   <= rd_idx_nxt;
    job_pass_r <= job_pass_nxt;
    job_num_r  <= job_num_nxt;
    job_den_r  <= job_den_nxt;
  end

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == W_IDLE && in_valid) |=> (st_r != W_IDLE))
    else $error("sequencer idle right after accepting a beat");

  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == W_JOB && job_ready && last_r) |=> (fill_r == '0 && !sum_ok_r))
    else $error("series state not cleared after last beat");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r <= IDX_W'(LINE_DEPTH)))
    else $error("fill count beyond line depth");
`endif

endmodule

`default_nettype wire

>>> design/cma_div.sv
// ----------------------------------------------------------------------------
// cma_div
// Iterative radix-4 restoring divider: signed numerator by small unsigned
// divisor, quotient truncated toward zero; pass-through jobs skip the loop.
// ----------------------------------------------------------------------------
`default_nettype none

module cma_div import cma_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int NUM_W        = 24,
  parameter int DEN_W        = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           job_valid,
  output logic                           job_ready,
  input  cma_job_ctl_t                   job_ctl,
  input  logic signed [NUM_W-1:0]        job_num,
  input  logic [DEN_W-1:0]               job_den,
  output logic                           res_valid,
  input  logic                           res_ready,
  output logic signed [SAMPLE_WIDTH-1:0] res_average,
  output logic                           res_last
);

  localparam int STEPS  = (NUM_W + 1) / 2;
  localparam int A_W    = 2 * STEPS;
  localparam int STEP_W = $clog2(STEPS + 1);

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_RUN  = 3'b010,
    D_DONE = 3'b100
  } div_state_t;

  div_state_t st_r, st_nxt;

  logic [A_W-1:0]          a_r, a_nxt, a_w;
  logic [DEN_W-1:0]        rem_r, rem_nxt, r_w, den_r, den_nxt;
  logic [DEN_W:0]          t_w;
  logic                    ge_w;
  logic                    neg_r, neg_nxt, last_r, last_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic [SAMPLE_WIDTH-1:0] avg_r, avg_nxt, q_w;
  logic [NUM_W-1:0]        mag;

  assign mag = job_num[NUM_W-1] ? -job_num : job_num;
  assign q_w = a_w[SAMPLE_WIDTH-1:0];

  assign job_ready   = (st_r == D_IDLE);
  assign res_valid   = (st_r == D_DONE);
  assign res_average = avg_r;
  assign res_last    = last_r;

  always_comb begin
    a_w  = a_r;
    r_w  = rem_r;
    t_w  = '0;
    ge_w = 1'b0;
    for (int k = 0; k < 2; k++) begin
      t_w  = {r_w, a_w[A_W-1]};
      ge_w = (t_w >= {1'b0, den_r});
      r_w  = ge_w ? DEN_W'(t_w - {1'b0, den_r}) : t_w[DEN_W-1:0];
      a_w  = {a_w[A_W-2:0], ge_w};
    end
  end

  always_comb begin
    st_nxt   = st_r;
    a_nxt    = a_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    last_nxt = last_r;
    step_nxt = step_r;
    avg_nxt  = avg_r;
    unique case (st_r)
      D_IDLE: begin
        if (job_valid) begin
          last_nxt = job_ctl.last;
          if (job_ctl.pass) begin
            avg_nxt = job_num[SAMPLE_WIDTH-1:0];
            st_nxt  = D_DONE;
          end else begin
            neg_nxt  = job_num[NUM_W-1];
            a_nxt    = A_W'(mag);
            rem_nxt  = '0;
            den_nxt  = job_den;
            step_nxt = '0;
            st_nxt   = D_RUN;
          end
        end
      end
      D_RUN: begin
        a_nxt    = a_w;
        rem_nxt  = r_w;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(STEPS - 1)) begin
          avg_nxt = neg_r ? -q_w : q_w;
          st_nxt  = D_DONE;
        end
      end
      D_DONE: begin
        if (res_ready) begin
          st_nxt = D_IDLE;
        end
      end
      default: st_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      step_r <= '0;
    end else begin
      st_r   <= st_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    neg_r  <= neg_nxt;
    last_r <= last_nxt;
    avg_r  <= avg_nxt;
  end

`ifndef NO_ASSERTIONS
  a_pass_done: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == D_IDLE && job_valid && job_ctl.pass) |=> res_valid)
    else $error("pass-through job did not complete in one cycle");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == D_RUN) |-> (step_r < STEP_W'(STEPS)))
    else $error("divider step count out of range");
`endif

endmodule

`default_nettype wire

>>> test/centered_moving_average_core_test.sv
// ----------------------------------------------------------------------------
// centered_moving_average_core_test
// Drives sample series into the core, holds its own model of the delay line,
// the window length and the fill count, and checks every average beat field
// by field. A directed table covers the sample extremes, short series,
// pass-through, even and odd lengths and a length above range. Random phases
// then vary the window length between series and mid-series, with random
// idling on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module centered_moving_average_core_test import cma_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WIN      = 64;
  localparam int LINE_DEPTH   = MAX_WIN + 1;
  localparam int SW           = 16;
  localparam int RANDOM_BEATS = 900;
  localparam int SETTLE       = 150;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 4000;
  localparam int PLAN_ROWS    = 29;

  typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [WIN_LEN_W-1:0]   len;
    logic signed [SW-1:0]   sample;
    logic                   series_end;
    bit                     typed;
    logic signed [SW-1:0]   avg;
  } plan_row_t;

  typedef struct packed {
    logic signed [SW-1:0] average;
    logic                 series_last;
  } result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [CFG_AW-1:0]    paddr;
  logic [CFG_DW-1:0]    pwdata;
  logic [CFG_DW-1:0]    prdata;
  logic                 pready;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [SW-1:0] in_sample;
  logic                 in_series_end;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [SW-1:0] out_average;
  logic                 out_result_last;

  logic signed [SW-1:0] line_mem [LINE_DEPTH];
  int                   held_cnt;
  logic [WIN_LEN_W-1:0] win_len;

  result_t avg_due [$];
  int      mismatches;
  int      random_sent;
  int      quiet_cycles;
  bit      burst_send;
  bit      burst_recv;
  bit      hold_out;

  plan_row_t plan [PLAN_ROWS] = '{
    '{ROW_BEAT,  7'd0,   16'sh7fff, 1'b0, 1'b0, 16'sh0000},
    '{ROW_BEAT,  7'd0,   16'sh7fff, 1'b0, 1'b0, 16'sh0000},
    '{ROW_BEAT,  7'd0,   16'sh7fff, 1'b1, 1'b1, 16'sh7fff},
    '{ROW_BEAT,  7'd0,   16'sh8000, 1'b0, 1'b0, 16'sh0000},
    '{ROW_BEAT,  7'd0,   16'sh8000, 1'b0, 1'b0, 16'sh0000},
    '{ROW_BEAT,  7'd0,   16'sh8000, 1'b1, 1'b1, 16'sh8000},
    '{ROW_BEAT,  7'd0,   16'sd100,  1'b1, 1'b1, 16'sd100},
    '{ROW_BEAT,  7'd0,   16'sd5,    1'b0, 1'b0, 16'sh0000},
    '{ROW_BEAT,  7'd0,   -16'sd8,   1'b1, 1'b1, -16'sd1},
    '{ROW_WRITE, 7'd0,   16'sh0000, 1'b0, 1'b0, 16'sh0000},
    '{ROW_BEAT,  7'd0,   16'sh8000, 1'b0, 1'b1, 16'sh8000},
    '{ROW_BEAT,  7'd0,   16'sh7fff, 1'b1, 1'b1, 16'sh7fff},
    '{ROW_WRITE, 7'd2,   16'sh0000, 1'b0, 1'b0, 16'sh0000},
    '{ROW_BEAT,  7'd0,   16'sd4,    1'b0, 1'b0, 16'sh0000},
    '{ROW_BEAT,  7'd0,   16'sd8,    1'b0, 1'b0, 16'sh0000},
    '{ROW_BEAT,  7'd0,   16'sd20,   1'b0, 1'b0, 16'sh0000},
    '{ROW_WRITE, 7'd5,   16'sh0000, 1'b0, 1'b0, 16'sh0000},
    '{ROW_BEAT,  7'd0,   -16'sd7,   1'b1, 1'b0, 16'sh0000},
    '{ROW_WRITE, 7'd64,  16'sh0000, 1'b0, 1'b0, 16'sh0000},
    '{ROW_BEAT,  7'd0,   16'sh8000, 1'b0, 1'b0, 16'sh0000},
    '{ROW_BEAT,  7'd0,   16'sh7fff, 1'b0, 1'b0, 16'sh0000},
    '{ROW_BEAT,  7'd0,   -16'sd1,   1'b1, 1'b0, 16'sh0000},
    '{ROW_WRITE, 7'd127, 16'sh0000, 1'b0, 1'b0, 16'sh0000},
    '{ROW_BEAT,  7'd0,   16'sh7fff, 1'b0, 1'b0, 16'sh0000},
    '{ROW_BEAT,  7'd0,   16'sh7fff, 1'b0, 1'b0, 16'sh0000},
    '{ROW_BEAT,  7'd0,   16'sh7ffe, 1'b1, 1'b0, 16'sh0000},
    '{ROW_WRITE, 7'd1,   16'sh0000, 1'b0, 1'b0, 16'sh0000},
    '{ROW_BEAT,  7'd0,   16'sd1234, 1'b1, 1'b1, 16'sd1234},
    '{ROW_WRITE, 7'd3,   16'sh0000, 1'b0, 1'b0, 16'sh0000}
  };

  centered_moving_average_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .in_series_end  (in_series_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_average    (out_average),
    .out_result_last(out_result_last)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic void clear_line();
    foreach (line_mem[i]) line_mem[i] = '0;
    held_cnt = 0;
  endfunction

  function automatic int effective_len();
    return (win_len > MAX_WIN) ? MAX_WIN : int'(win_len);
  endfunction

  // shift the sample in and return whether it yields an average beat
  function automatic bit smooth_sample(input logic signed [SW-1:0] s, input logic last,
                                       output logic signed [SW-1:0] avg);
    longint total;
    longint num;
    int     m;
    int     span;
    bit     got;
    for (int i = LINE_DEPTH - 1; i > 0; i--) line_mem[i] = line_mem[i-1];
    line_mem[0] = s;
    if (held_cnt < LINE_DEPTH) held_cnt++;
    m   = effective_len();
    got = 1'b0;
    avg = '0;
    if (m <= 1) begin
      avg = s;
      got = 1'b1;
    end else begin
      span  = (m % 2 == 0) ? m + 1 : m;
      total = 0;
      for (int i = 0; i < span && i < held_cnt; i++) total += longint'(line_mem[i]);
      if (held_cnt >= span) begin
        num = 2 * total;
        if (m % 2 == 0) num -= longint'(line_mem[0]) + longint'(line_mem[span-1]);
        avg = SW'(num / longint'(2 * m));
        got = 1'b1;
      end else if (last) begin
        avg = SW'(total / longint'(held_cnt));
        got = 1'b1;
      end
    end
    if (last) clear_line();
    return got;
  endfunction

  function automatic void flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  task automatic send_sample(input logic signed [SW-1:0] s, input logic e,
                             input bit typed, input logic signed [SW-1:0] typed_avg);
    int                   gap;
    logic signed [SW-1:0] want;
    gap = burst_send ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_sample     <= s;
    in_series_end <= e;
    do @(posedge clk); while (in_stall);
    if (smooth_sample(s, e, want)) avg_due.push_back('{typed ? typed_avg : want, e});
  endtask

  task automatic write_window(input logic [WIN_LEN_W-1:0] len);
    logic [CFG_DW-1:0] rd;
    @(negedge clk);
    in_valid <= 1'b0;
    while (avg_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_WINDOW_LEN, 2'b00};
    pwdata  <= CFG_DW'(len);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    win_len = len;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[WIN_LEN_W-1:0] !== len)
      flag_error($sformatf("window_len readback: expected %0d actual %0d",
                           len, rd[WIN_LEN_W-1:0]));
  endtask

  function automatic logic [WIN_LEN_W-1:0] pick_len();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return WIN_LEN_W'(1);
      2:       return WIN_LEN_W'(MAX_WIN);
      3:       return WIN_LEN_W'($urandom_range(MAX_WIN + 1, 127));
      4:       return WIN_LEN_W'($urandom_range(9, MAX_WIN - 1));
      default: return WIN_LEN_W'($urandom_range(2, 8));
    endcase
  endfunction

  function automatic int pick_series_len();
    int m;
    int span;
    m    = effective_len();
    span = (m <= 1) ? 1 : ((m % 2 == 0) ? m + 1 : m);
    case ($urandom_range(0, 7))
      0, 1:    return $urandom_range(1, span);
      6:       return $urandom_range(span + 25, 3 * span + 30);
      7:       return 1;
      default: return $urandom_range(span, span + 24);
    endcase
  endfunction

  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return SW'(int'($urandom_range(0, 15)) - 8);
      default: return SW'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    result_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (avg_due.size() == 0) begin
        flag_error($sformatf("unexpected beat: average %0d last %0b",
                             out_average, out_result_last));
      end else begin
        due = avg_due.pop_front();
        if (out_average !== due.average)
          flag_error($sformatf("average: expected %0d actual %0d",
                               $signed(due.average), out_average));
        if (out_result_last !== due.series_last)
          flag_error($sformatf("result_last: expected %0b actual %0b",
                               due.series_last, out_result_last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_out) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_out = 1'b0;
      end else begin
        n = burst_recv ? 0 : $urandom_range(0, 11);
        if (n > 0) begin
          @(negedge clk);
          out_stall <= 1'b1;
          repeat (n - 1) @(negedge clk);
          @(negedge clk);
          out_stall <= 1'b0;
        end
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int phase;
    int phase_len;
    int series_left;
    logic signed [SW-1:0] s;
    rst_n         = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid      = 1'b0;
    in_sample     = '0;
    in_series_end = 1'b0;
    burst_send    = 1'b0;
    burst_recv    = 1'b0;
    hold_out      = 1'b0;
    mismatches    = 0;
    random_sent   = 0;
    quiet_cycles  = 0;
    win_len       = WIN_LEN_RESET;
    clear_line();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_WRITE)
        write_window(plan[r].len);
      else
        send_sample(plan[r].sample, plan[r].series_end, plan[r].typed, plan[r].avg);
    end

    phase       = 0;
    series_left = 0;
    while (random_sent < RANDOM_BEATS) begin
      write_window(phase == 1 ? WIN_LEN_W'(3) : pick_len());
      burst_send = ($urandom_range(0, 3) == 0);
      burst_recv = ($urandom_range(0, 3) == 0);
      phase_len  = $urandom_range(30, 90);
      if (phase == 1) begin
        burst_send = 1'b1;
        burst_recv = 1'b0;
        hold_out   = 1'b1;
        phase_len  = 120;
      end
      repeat (phase_len) begin
        if (series_left == 0) series_left = pick_series_len();
        s = pick_sample();
        send_sample(s, series_left == 1, 1'b0, '0);
        series_left--;
        random_sent++;
      end
      phase++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (avg_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && avg_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/cma_pkg.sv
design/cma_regs.sv
design/cma_window.sv
design/cma_div.sv
design/centered_moving_average_core.sv
test/centered_moving_average_core_test.sv
